>>> rtl/rv32ie_pkg.sv
package rv32ie_pkg;

  // Operation codes; codes above the last branch are no-ops
  typedef enum logic [4:0] {
    CMD_ADD   = 5'd0,
    CMD_ADDI  = 5'd1,
    CMD_SUB   = 5'd2,
    CMD_AND   = 5'd3,
    CMD_ANDI  = 5'd4,
    CMD_OR    = 5'd5,
    CMD_ORI   = 5'd6,
    CMD_XOR   = 5'd7,
    CMD_XORI  = 5'd8,
    CMD_SLTI  = 5'd9,
    CMD_SLTIU = 5'd10,
    CMD_SLLI  = 5'd11,
    CMD_SRLI  = 5'd12,
    CMD_SRAI  = 5'd13,
    CMD_LB    = 5'd14,
    CMD_LH    = 5'd15,
    CMD_LW    = 5'd16,
    CMD_SB    = 5'd17,
    CMD_SH    = 5'd18,
    CMD_SW    = 5'd19,
    CMD_LUI   = 5'd20,
    CMD_JAL   = 5'd21,
    CMD_JALR  = 5'd22,
    CMD_BEQ   = 5'd23,
    CMD_BNE   = 5'd24,
    CMD_BLT   = 5'd25,
    CMD_BGE   = 5'd26,
    CMD_BLTU  = 5'd27,
    CMD_BGEU  = 5'd28
  } cmd_e;

  // Memory access size
  typedef enum logic [1:0] {
    SIZE_B,
    SIZE_H,
    SIZE_W
  } size_e;

  localparam logic [31:0] PcStep   = 32'd4;
  localparam int          LuiShift = 12;
  localparam logic [31:0] JalrMask = ~(32'd1 << 0);

  typedef struct packed {
    logic [4:0]         command;
    logic [4:0]         rs1_index;
    logic [4:0]         rs2_index;
    logic [4:0]         rd_index;
    logic signed [31:0] immediate;
  } item_t;

  // Outcome of the execute logic for one instruction
  typedef struct packed {
    logic [31:0] next_pc;
    logic        wr;
    logic [4:0]  rd;
    logic [31:0] val;
    logic        taken;
    logic        is_mem;
    logic        is_load;
    logic        is_store;
    size_e       size;
    logic        sign;
    logic [31:0] addr;
  } exec_t;

endpackage

>>> rtl/rv32ie_if.sv
// Instruction channel
interface rv32ie_in_if;
  logic               valid;
  logic               ready;
  logic [4:0]         command;
  logic [4:0]         rs1_index;
  logic [4:0]         rs2_index;
  logic [4:0]         rd_index;
  logic signed [31:0] immediate;

  modport source (output valid, command, rs1_index, rs2_index, rd_index, immediate,
                  input ready);
  modport sink   (input valid, command, rs1_index, rs2_index, rd_index, immediate,
                  output ready);
endinterface

// Result channel
interface rv32ie_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic        reg_write;
  logic [4:0]  reg_write_index;
  logic [31:0] reg_write_value;
  logic        branch_taken;
  logic [31:0] mem_address;
  logic        mem_written;

  modport source (output valid, next_pc, reg_write, reg_write_index, reg_write_value,
                  branch_taken, mem_address, mem_written,
                  input ready);
  modport sink   (input valid, next_pc, reg_write, reg_write_index, reg_write_value,
                  branch_taken, mem_address, mem_written,
                  output ready);
endinterface

>>> rtl/rv32ie_ram.sv
module rv32ie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/rv32ie_exec.sv
module rv32ie_exec (
  input  rv32ie_pkg::item_t item_i,
  input  logic [31:0]       a_i,
  input  logic [31:0]       b_i,
  input  logic [31:0]       pc_i,
  output rv32ie_pkg::exec_t res_o
);

  logic [31:0] imm;
  logic [31:0] addr;
  logic [31:0] pc_seq;
  logic [31:0] pc_rel;
  logic [4:0]  shamt;
  logic        cond;
  logic        branch;

  assign imm    = item_i.immediate;
  assign addr   = a_i + imm;
  assign pc_seq = pc_i + rv32ie_pkg::PcStep;
  assign pc_rel = pc_i + imm;
  assign shamt  = imm[4:0];

  // Decode the operation and form the result
  always_comb begin
    res_o          = '0;
    res_o.next_pc  = pc_seq;
    res_o.rd       = item_i.rd_index;
    res_o.addr     = addr;
    res_o.size     = rv32ie_pkg::SIZE_W;
    cond           = 1'b0;
    branch         = 1'b0;
    case (rv32ie_pkg::cmd_e'(item_i.command))
      rv32ie_pkg::CMD_ADD:   begin res_o.val = a_i + b_i; res_o.wr = 1'b1; end
      rv32ie_pkg::CMD_ADDI:  begin res_o.val = addr;      res_o.wr = 1'b1; end
      rv32ie_pkg::CMD_SUB:   begin res_o.val = a_i - b_i; res_o.wr = 1'b1; end
      rv32ie_pkg::CMD_AND:   begin res_o.val = a_i & b_i; res_o.wr = 1'b1; end
      rv32ie_pkg::CMD_ANDI:  begin res_o.val = a_i & imm; res_o.wr = 1'b1; end
      rv32ie_pkg::CMD_OR:    begin res_o.val = a_i | b_i; res_o.wr = 1'b1; end
      rv32ie_pkg::CMD_ORI:   begin res_o.val = a_i | imm; res_o.wr = 1'b1; end
      rv32ie_pkg::CMD_XOR:   begin res_o.val = a_i ^ b_i; res_o.wr = 1'b1; end
      rv32ie_pkg::CMD_XORI:  begin res_o.val = a_i ^ imm; res_o.wr = 1'b1; end
      rv32ie_pkg::CMD_SLTI: begin
        res_o.val = {31'd0, $signed(a_i) < $signed(imm)};
        res_o.wr  = 1'b1;
      end
      rv32ie_pkg::CMD_SLTIU: begin
        res_o.val = {31'd0, a_i < imm};
        res_o.wr  = 1'b1;
      end
      rv32ie_pkg::CMD_SLLI:  begin res_o.val = a_i << shamt; res_o.wr = 1'b1; end
      rv32ie_pkg::CMD_SRLI:  begin res_o.val = a_i >> shamt; res_o.wr = 1'b1; end
      rv32ie_pkg::CMD_SRAI: begin
        res_o.val = $unsigned($signed(a_i) >>> shamt);
        res_o.wr  = 1'b1;
      end
      rv32ie_pkg::CMD_LB: begin
        res_o.wr = 1'b1; res_o.is_mem = 1'b1; res_o.is_load = 1'b1;
        res_o.size = rv32ie_pkg::SIZE_B; res_o.sign = 1'b1;
      end
      rv32ie_pkg::CMD_LH: begin
        res_o.wr = 1'b1; res_o.is_mem = 1'b1; res_o.is_load = 1'b1;
        res_o.size = rv32ie_pkg::SIZE_H; res_o.sign = 1'b1;
      end
      rv32ie_pkg::CMD_LW: begin
        res_o.wr = 1'b1; res_o.is_mem = 1'b1; res_o.is_load = 1'b1;
        res_o.size = rv32ie_pkg::SIZE_W;
      end
      rv32ie_pkg::CMD_SB: begin
        res_o.is_mem = 1'b1; res_o.is_store = 1'b1; res_o.size = rv32ie_pkg::SIZE_B;
      end
      rv32ie_pkg::CMD_SH: begin
        res_o.is_mem = 1'b1; res_o.is_store = 1'b1; res_o.size = rv32ie_pkg::SIZE_H;
      end
      rv32ie_pkg::CMD_SW: begin
        res_o.is_mem = 1'b1; res_o.is_store = 1'b1; res_o.size = rv32ie_pkg::SIZE_W;
      end
      rv32ie_pkg::CMD_LUI: begin
        res_o.val = imm << rv32ie_pkg::LuiShift;
        res_o.wr  = 1'b1;
      end
      rv32ie_pkg::CMD_JAL: begin
        res_o.val = pc_seq; res_o.wr = 1'b1;
        res_o.next_pc = pc_rel; res_o.taken = 1'b1;
      end
      rv32ie_pkg::CMD_JALR: begin
        res_o.val = pc_seq; res_o.wr = 1'b1;
        res_o.next_pc = addr & rv32ie_pkg::JalrMask; res_o.taken = 1'b1;
      end
      rv32ie_pkg::CMD_BEQ:  begin cond = (a_i == b_i);                branch = 1'b1; end
      rv32ie_pkg::CMD_BNE:  begin cond = (a_i != b_i);                branch = 1'b1; end
      rv32ie_pkg::CMD_BLT:  begin cond = ($signed(a_i) < $signed(b_i));  branch = 1'b1; end
      rv32ie_pkg::CMD_BGE:  begin cond = ($signed(a_i) >= $signed(b_i)); branch = 1'b1; end
      rv32ie_pkg::CMD_BLTU: begin cond = (a_i < b_i);                 branch = 1'b1; end
      rv32ie_pkg::CMD_BGEU: begin cond = (a_i >= b_i);                branch = 1'b1; end
      default: ;
    endcase

    // Redirect on a taken branch
    if (branch && cond) begin
      res_o.next_pc = pc_rel;
      res_o.taken   = 1'b1;
    end

    // Drop writes to x0
    if (item_i.rd_index == 5'd0) begin
      res_o.wr = 1'b0;
    end
  end

endmodule

>>> rtl/rv32i_instruction_execute_top.sv
// RV32I execute stage.
// in_i carries one decoded instruction per beat (operation, rs1, rs2, rd,
// sign-extended immediate); out_o returns one result beat per
// instruction: next pc, register write, branch flag, memory address, store flag.
// Pipeline: the accept edge reads both register-file RAMs; stage 1 then
// forwards operands, executes, updates the pc and writes or reads data memory
// as it advances, at the edge that loads the result stage. A result is valid
// from the edge after its instruction is accepted unless the result stage is
// held, and a new instruction is taken every cycle while out_o.ready is high.
// The result stage writes the register file when its beat leaves; pending
// writes are forwarded to younger instructions, loads included.
// Data memory is four byte-lane RAMs of MEM_BYTES/4 rows each (MEM_BYTES is a
// power of two); unaligned accesses split across lanes and wrap at the end.
// Reset clears the pc and the register-file valid bits, so every register
// reads zero at once; data memory is not cleared and must be written first.
// When out_o.ready is low the result stage and the stage behind it hold, and
// in_i.ready drops once both are full.
module rv32i_instruction_execute_top #(
  parameter int MEM_BYTES = 4096
) (
  input logic         clk_i,
  input logic         rst_ni,
  rv32ie_in_if.sink   in_i,
  rv32ie_out_if.source out_o
);

  localparam int Rows = MEM_BYTES / 4;
  localparam int RowW = $clog2(Rows);

  logic               in_beat;
  logic               out_beat;
  logic               s1_adv;
  logic               s1_valid_q;
  rv32ie_pkg::item_t  s1_item_q;
  logic               s2_valid_q;
  rv32ie_pkg::exec_t  s2_q;
  rv32ie_pkg::exec_t  s1_res;
  logic [31:0]        pc_q;

  logic [31:0]        rf_valid_q;
  logic               a_vld_q;
  logic               b_vld_q;
  logic [31:0]        a_ram;
  logic [31:0]        b_ram;
  logic               rf_we;
  logic               byp_valid_q;
  logic [4:0]         byp_idx_q;
  logic [31:0]        byp_val_q;
  logic [31:0]        a_eff;
  logic [31:0]        b_eff;

  logic [3:0][7:0]    lane_rdata;
  logic [3:0][7:0]    ld_byte;
  logic [31:0]        ld_val;
  logic [31:0]        s2_val;
  logic [RowW-1:0]    row_base;

  // Handshake and stage advance
  assign s1_adv     = s1_valid_q && (!s2_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_beat    = in_i.valid && in_i.ready;
  assign out_beat   = s2_valid_q && out_o.ready;
  assign rf_we      = out_beat && s2_q.wr;

  // Stage 1 register: instruction waiting for operands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      a_vld_q    <= 1'b0;
      b_vld_q    <= 1'b0;
    end else begin
      if (in_beat) begin
        s1_valid_q <= 1'b1;
        a_vld_q    <= rf_valid_q[in_i.rs1_index];
        b_vld_q    <= rf_valid_q[in_i.rs2_index];
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      s1_item_q.command   <= in_i.command;
      s1_item_q.rs1_index <= in_i.rs1_index;
      s1_item_q.rs2_index <= in_i.rs2_index;
      s1_item_q.rd_index  <= in_i.rd_index;
      s1_item_q.immediate <= in_i.immediate;
    end
  end

  // Register file: two read copies, written together
  rv32ie_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (s2_q.rd),
    .wdata_i (s2_val),
    .re_i    (in_beat),
    .raddr_i (in_i.rs1_index),
    .rdata_o (a_ram)
  );

  rv32ie_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (s2_q.rd),
    .wdata_i (s2_val),
    .re_i    (in_beat),
    .raddr_i (in_i.rs2_index),
    .rdata_o (b_ram)
  );

  // Track written registers and hold the last write for forwarding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_valid_q  <= '0;
      byp_valid_q <= 1'b0;
    end else if (rf_we) begin
      rf_valid_q[s2_q.rd] <= 1'b1;
      byp_valid_q         <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      byp_idx_q <= s2_q.rd;
      byp_val_q <= s2_val;
    end
  end

  // Forward operands: result stage first, then the last write, then the RAM
  always_comb begin
    if (s2_valid_q && s2_q.wr && (s2_q.rd == s1_item_q.rs1_index)) begin
      a_eff = s2_val;
    end else if (byp_valid_q && (byp_idx_q == s1_item_q.rs1_index)) begin
      a_eff = byp_val_q;
    end else if (a_vld_q) begin
      a_eff = a_ram;
    end else begin
      a_eff = '0;
    end
    if (s2_valid_q && s2_q.wr && (s2_q.rd == s1_item_q.rs2_index)) begin
      b_eff = s2_val;
    end else if (byp_valid_q && (byp_idx_q == s1_item_q.rs2_index)) begin
      b_eff = byp_val_q;
    end else if (b_vld_q) begin
      b_eff = b_ram;
    end else begin
      b_eff = '0;
    end
  end

  rv32ie_exec u_exec (
    .item_i (s1_item_q),
    .a_i    (a_eff),
    .b_i    (b_eff),
    .pc_i   (pc_q),
    .res_o  (s1_res)
  );

  // Advance the pc in program order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else if (s1_adv) begin
      pc_q <= s1_res.next_pc;
    end
  end

  // Data memory lanes; lane j holds bytes whose address ends in j
  assign row_base = s1_res.addr[RowW+1:2];

  for (genvar j = 0; j < 4; j++) begin : g_lane
    logic [1:0]      k;
    logic [RowW-1:0] row;
    logic            lane_en;
    logic [7:0]      wdata;

    assign k   = 2'(j) - s1_res.addr[1:0];
    assign row = (2'(j) >= s1_res.addr[1:0]) ? row_base : RowW'(row_base + RowW'(1));

    always_comb begin
      case (s1_res.size)
        rv32ie_pkg::SIZE_B: lane_en = (k == 2'd0);
        rv32ie_pkg::SIZE_H: lane_en = (k < 2'd2);
        rv32ie_pkg::SIZE_W: lane_en = 1'b1;
        default:            lane_en = 1'b0;
      endcase
    end

    assign wdata = b_eff[{k, 3'b000} +: 8];

    rv32ie_ram #(.WIDTH(8), .DEPTH(Rows)) u_dmem (
      .clk_i   (clk_i),
      .we_i    (s1_adv && s1_res.is_store && lane_en),
      .waddr_i (row),
      .wdata_i (wdata),
      .re_i    (s1_adv && s1_res.is_load),
      .raddr_i (row),
      .rdata_o (lane_rdata[j])
    );
  end

  // Result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s2_valid_q <= 1'b1;
    end else if (out_beat) begin
      s2_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_q <= s1_res;
    end
  end

  // Gather load bytes in address order and extend
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ld_byte[k] = lane_rdata[2'(2'(k) + s2_q.addr[1:0])];
    end
    case (s2_q.size)
      rv32ie_pkg::SIZE_B: ld_val = {{24{ld_byte[0][7]}}, ld_byte[0]};
      rv32ie_pkg::SIZE_H: ld_val = {{16{ld_byte[1][7] & s2_q.sign}}, ld_byte[1], ld_byte[0]};
      rv32ie_pkg::SIZE_W: ld_val = ld_byte;
      default:            ld_val = '0;
    endcase
  end

  assign s2_val = s2_q.is_load ? ld_val : s2_q.val;

  // Drive the result beat
  assign out_o.valid           = s2_valid_q;
  assign out_o.next_pc         = s2_q.next_pc;
  assign out_o.reg_write       = s2_q.wr;
  assign out_o.reg_write_index = s2_q.wr ? s2_q.rd : 5'd0;
  assign out_o.reg_write_value = s2_q.wr ? s2_val : 32'd0;
  assign out_o.branch_taken    = s2_q.taken;
  assign out_o.mem_address     = s2_q.is_mem ? s2_q.addr : 32'd0;
  assign out_o.mem_written     = s2_q.is_store;

endmodule
